// ===== hw/rtl/chse_pkg.sv =====
// chse_pkg: shared widths, constants and types of the header symbol encoder
// no dependencies; compiled before every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package chse_pkg;

    // configuration register
    localparam int SF_W       = 4;
    localparam int SF_RESET   = 7;
    localparam int MIN_SF     = 5;
    localparam int MAX_SF_DEF = 12;

    // request fields
    localparam int LEN_W  = 8;
    localparam int CR_W   = 3;
    localparam int CR_MIN = 1;
    localparam int CR_MAX = 4;

    // result fields
    localparam int SYM_W       = 12;
    localparam int IDX_W       = 3;
    localparam int HDR_SYMBOLS = 8;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_SYMBOLS - 1);

    // coding
    localparam int NIB_W   = 4;
    localparam int NIBBLES = 5;
    localparam int CW_BITS = 8;
    localparam int CHK_W   = 5;

    // side info that travels with one interleaved column
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             bad;
    } col_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/chse_req_if.sv =====
// chse_req_if: request channel (payload length, crc flag, coding rate)
// depends on chse_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface chse_req_if;
    logic                           valid;
    logic                           ready;
    logic [chse_pkg::LEN_W-1:0]     payload_length;
    logic                           crc_present;
    logic [chse_pkg::CR_W-1:0]      coding_rate;

    modport source (output valid, output payload_length, output crc_present,
                    output coding_rate, input ready);
    modport sink   (input valid, input payload_length, input crc_present,
                    input coding_rate, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/chse_sym_if.sv =====
// chse_sym_if: symbol result channel (symbol, index, last, bad_params)
// depends on chse_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface chse_sym_if;
    logic                           valid;
    logic                           ready;
    logic [chse_pkg::SYM_W-1:0]     symbol;
    logic [chse_pkg::IDX_W-1:0]     symbol_index;
    logic                           last;
    logic                           bad_params;

    modport source (output valid, output symbol, output symbol_index,
                    output last, output bad_params, input ready);
    modport sink   (input valid, input symbol, input symbol_index,
                    input last, input bad_params, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/chse_encode.sv =====
// chse_encode: checksum and hamming stage, column sequencer and interleave stage
// depends on chse_pkg and chse_req_if
`timescale 1ns / 1ps
`default_nettype none

module chse_encode #(
    parameter int  MAX_SF = chse_pkg::MAX_SF_DEF,
    localparam int WordW  = MAX_SF - 2,
    localparam int NumR   = MAX_SF - 4,
    localparam int RselW  = $clog2(NumR)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    chse_req_if.sink                    req,
    input  wire logic [RselW-1:0]       rsel,
    input  wire logic                   down_ready,
    output logic                        col_valid,
    output logic [WordW-1:0]            col_word,
    output chse_pkg::col_info_t         col_info
);

    localparam logic [11:0] CHK_ROWS [chse_pkg::CHK_W] =
        '{12'hF00, 12'h8E8, 12'h495, 12'h25B, 12'h12F};

    function automatic logic [chse_pkg::CHK_W-1:0] header_checksum(
        input logic [chse_pkg::LEN_W-1:0] len,
        input logic                       crc,
        input logic [chse_pkg::CR_W-1:0]  cr
    );
        logic [11:0]                   h;
        logic [chse_pkg::CHK_W-1:0]    c;
        h = {len, crc, cr};
        for (int r = 0; r < chse_pkg::CHK_W; r++)
        begin
            c[chse_pkg::CHK_W-1-r] = ^(h & CHK_ROWS[r]);
        end
        return c;
    endfunction

    // data bits reversed into the top nibble, parity below
    function automatic logic [chse_pkg::CW_BITS-1:0] hamming84(
        input logic [chse_pkg::NIB_W-1:0] d
    );
        logic b7, b6, b5, b4, b3, b2, b1, b0;
        b7 = d[0];
        b6 = d[1];
        b5 = d[2];
        b4 = d[3];
        b3 = b7 ^ b6 ^ b5;
        b2 = b6 ^ b5 ^ b4;
        b1 = b7 ^ b6 ^ b4;
        b0 = b7 ^ b6 ^ b5 ^ b4 ^ b3 ^ b2 ^ b1;
        return {b7, b6, b5, b4, b3, b2, b1, b0};
    endfunction

    // stage 1: codewords of one request, walked column by column
    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_bad_reg;
    logic [chse_pkg::IDX_W-1:0]     col_reg, col_next;
    logic [chse_pkg::CW_BITS-1:0]   cw_reg [chse_pkg::NIBBLES];
    logic [chse_pkg::CW_BITS-1:0]   cw_in  [chse_pkg::NIBBLES];
    logic [chse_pkg::NIB_W-1:0]     nib    [chse_pkg::NIBBLES];
    logic [chse_pkg::CHK_W-1:0]     chk;
    logic                           bad_in;

    // stage 2: one interleaved column word
    logic                           s2_valid_reg, s2_valid_next;
    logic [WordW-1:0]               word_reg, word_next;
    chse_pkg::col_info_t            info_reg, info_next;

    logic s2_ready;
    logic s1_move;
    logic s1_done;
    logic accept;

    assign s2_ready  = !s2_valid_reg || down_ready;
    assign s1_move   = s1_valid_reg && s2_ready;
    assign s1_done   = s1_bad_reg || (col_reg == chse_pkg::LAST_IDX);
    assign req.ready = !s1_valid_reg || (s2_ready && s1_done);
    assign accept    = req.valid && req.ready;

    assign bad_in = (req.coding_rate < chse_pkg::CR_W'(chse_pkg::CR_MIN))
                 || (req.coding_rate > chse_pkg::CR_W'(chse_pkg::CR_MAX));

    always_comb
    begin
        chk    = header_checksum(req.payload_length, req.crc_present, req.coding_rate);
        nib[0] = req.payload_length[7:4];
        nib[1] = req.payload_length[3:0];
        nib[2] = {req.coding_rate, req.crc_present};
        nib[3] = {3'b000, chk[4]};
        nib[4] = chk[3:0];
        for (int i = 0; i < chse_pkg::NIBBLES; i++)
        begin
            cw_in[i] = hamming84(nib[i]);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        col_next      = col_reg;
        if (s1_move)
        begin
            if (s1_done)
            begin
                s1_valid_next = 1'b0;
                col_next      = '0;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            col_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            col_reg      <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cw_reg     <= cw_in;
            s1_bad_reg <= bad_in;
        end
    end

    // every (rows, column) pair is a fixed wiring of codeword bits;
    // word bit gb of column gc comes from row (gc + gb) mod rows
    wire [WordW-1:0] cand [NumR][chse_pkg::HDR_SYMBOLS];

    for (genvar gr = 0; gr < NumR; gr++)
    begin : g_rows
        localparam int R = gr + 3;
        for (genvar gc = 0; gc < chse_pkg::HDR_SYMBOLS; gc++)
        begin : g_col
            for (genvar gb = 0; gb < WordW; gb++)
            begin : g_bit
                localparam int Row = (gc + gb) % R;
                if (gb < R && Row < chse_pkg::NIBBLES)
                begin : g_cw
                    assign cand[gr][gc][gb] = cw_reg[Row][chse_pkg::CW_BITS-1-gc];
                end
                else
                begin : g_zero
                    assign cand[gr][gc][gb] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        word_next      = cand[rsel][col_reg];
        info_next.idx  = col_reg;
        info_next.last = s1_done;
        info_next.bad  = s1_bad_reg;
    end

    always_comb
    begin
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (down_ready)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            word_reg <= word_next;
            info_reg <= info_next;
        end
    end

    assign col_valid = s2_valid_reg;
    assign col_word  = word_reg;
    assign col_info  = info_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/chirp_header_symbol_encoder_top.sv =====
// Explicit-header symbol encoder for a chirp modem.
// One beat on req (payload_length, crc_present, coding_rate) turns into eight
// beats on sym, symbol_index 0..7, last on index 7. A coding rate outside 1..4
// gives a single beat instead: symbol 0, index 0, last and bad_params set.
// spreading_factor is written through cfg_we/cfg_data; the user must write it
// only while the block is idle; the block itself does not enforce this. Values below
// 5 act as 5 and values above MAX_SF act as MAX_SF. Pipeline: checksum and
// hamming register, interleave register, symbol output register. After the
// first symbol of a request shows on sym, the rest follow one symbol per
// cycle while sym.ready stays high.
// The column sequencer walks the held codewords one column per cycle while the
// interleave stage is not stalled, and takes the next request in the cycle its
// last column moves on.
// Reset: spreading factor back to 7, all stages empty, nothing in flight.
// A stall on sym holds the output beat; the stages behind it fill and then
// req.ready drops, so no beat is lost or repeated.
// depends on chse_pkg, chse_req_if, chse_sym_if and chse_encode
`timescale 1ns / 1ps
`default_nettype none

module chirp_header_symbol_encoder_top #(
    parameter int MAX_SF = chse_pkg::MAX_SF_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [chse_pkg::SF_W-1:0]  cfg_data,
    chse_req_if.sink                        req,
    chse_sym_if.source                      sym
);

    localparam int WordW = MAX_SF - 2;
    localparam int NumR  = MAX_SF - 4;
    localparam int RselW = $clog2(NumR);
    localparam int SfW   = chse_pkg::SF_W;
    localparam int SymW  = chse_pkg::SYM_W;

    logic [SfW-1:0]     sf_reg;
    logic [SfW-1:0]     sf_eff;
    logic [RselW-1:0]   rsel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg <= SfW'(chse_pkg::SF_RESET);
        end
        else if (cfg_we)
        begin
            sf_reg <= cfg_data;
        end
    end

    always_comb
    begin
        priority if (sf_reg < SfW'(chse_pkg::MIN_SF))
        begin
            sf_eff = SfW'(chse_pkg::MIN_SF);
        end
        else if (sf_reg > SfW'(MAX_SF))
        begin
            sf_eff = SfW'(MAX_SF);
        end
        else
        begin
            sf_eff = sf_reg;
        end
        rsel = RselW'(sf_eff - SfW'(chse_pkg::MIN_SF));
    end

    logic                   col_valid;
    logic [WordW-1:0]       col_word;
    chse_pkg::col_info_t    col_info;
    logic                   down_ready;

    chse_encode #(
        .MAX_SF (MAX_SF)
    ) u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsel       (rsel),
        .down_ready (down_ready),
        .col_valid  (col_valid),
        .col_word   (col_word),
        .col_info   (col_info)
    );

    // output stage: gray decode, shift left by two, plus one
    logic                       out_valid_reg, out_valid_next;
    logic [SymW-1:0]            symbol_reg, symbol_next;
    logic [chse_pkg::IDX_W-1:0] idx_reg;
    logic                       last_reg;
    logic                       bad_reg;
    logic [WordW-1:0]           bin;
    logic                       load;

    assign down_ready = !out_valid_reg || sym.ready;
    assign load       = col_valid && down_ready;

    always_comb
    begin
        for (int i = 0; i < WordW; i++)
        begin
            bin[i] = ^(col_word >> i);
        end
        // low bits of the shifted word are zero, so the increment never carries
        symbol_next = col_info.bad ? '0 : SymW'({bin, 2'b01});
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (sym.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            symbol_reg <= symbol_next;
            idx_reg    <= col_info.idx;
            last_reg   <= col_info.last;
            bad_reg    <= col_info.bad;
        end
    end

    assign sym.valid        = out_valid_reg;
    assign sym.symbol       = symbol_reg;
    assign sym.symbol_index = idx_reg;
    assign sym.last         = last_reg;
    assign sym.bad_params   = bad_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/chse_checker.sv =====
// chse_checker: port-level assertions on the symbol channel of the encoder
// depends on chse_pkg; bound to chirp_header_symbol_encoder_top at the end
`timescale 1ns / 1ps
`default_nettype none

module chse_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       sym_valid,
    input wire logic                       sym_ready,
    input wire logic [chse_pkg::SYM_W-1:0] sym_symbol,
    input wire logic [chse_pkg::IDX_W-1:0] sym_index,
    input wire logic                       sym_last,
    input wire logic                       sym_bad
);

    logic                       beat;
    logic [chse_pkg::IDX_W-1:0] exp_idx_reg, exp_idx_next;

    assign beat = sym_valid && sym_ready;

    always_comb
    begin
        exp_idx_next = exp_idx_reg;
        if (beat)
        begin
            exp_idx_next = sym_last ? '0 : sym_index + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else
        begin
            exp_idx_reg <= exp_idx_next;
        end
    end

    // indexes of one request run 0..7 with no gap
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        beat |-> sym_index == exp_idx_reg)
        else $error("symbol index out of order");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (sym_valid && !sym_bad) |-> (sym_last == (sym_index == chse_pkg::LAST_IDX)))
        else $error("last not on final symbol");

    a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (sym_valid && sym_bad) |-> (sym_symbol == '0 && sym_index == '0 && sym_last))
        else $error("malformed bad-parameter beat");

    a_symbol_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (sym_valid && !sym_bad) |-> sym_symbol[1:0] == 2'b01)
        else $error("symbol low bits not 01");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sym_valid && !sym_ready) |=> (sym_valid && $stable(sym_symbol)))
        else $error("stalled beat changed");

endmodule

bind chirp_header_symbol_encoder_top chse_checker u_chse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym_valid  (sym.valid),
    .sym_ready  (sym.ready),
    .sym_symbol (sym.symbol),
    .sym_index  (sym.symbol_index),
    .sym_last   (sym.last),
    .sym_bad    (sym.bad_params)
);

`default_nettype wire

// ===== test/chirp_header_symbol_encoder_top_tb.sv =====
// chirp_header_symbol_encoder_top_tb: self-checking bench for the header symbol encoder
// depends on chse_pkg, chse_req_if, chse_sym_if and chirp_header_symbol_encoder_top
// directed header table, then random requests across spreading factors
`timescale 1ns / 1ps

module chirp_header_symbol_encoder_top_tb;

    localparam int SF_CEIL    = chse_pkg::MAX_SF_DEF;
    localparam int N_DIRECTED = 24;
    localparam int N_PHASES   = 12;
    localparam int PHASE_REQS = 16;
    localparam int LONG_HOLD  = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [chse_pkg::SYM_W-1:0] symbol;
        logic [chse_pkg::IDX_W-1:0] idx;
        logic                       last;
        logic                       bad;
    } sym_beat_t;

    typedef struct packed {
        logic [chse_pkg::SF_W-1:0]  sf;
        logic [chse_pkg::LEN_W-1:0] len;
        logic                       crc;
        logic [chse_pkg::CR_W-1:0]  cr;
        bit                         typed;
        sym_beat_t                  want;
    } header_case_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [chse_pkg::SF_W-1:0] cfg_data;

    chse_req_if req_ch();
    chse_sym_if sym_ch();

    chirp_header_symbol_encoder_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .sym      (sym_ch)
    );

    sym_beat_t                 symbols_due[$];
    logic [chse_pkg::SF_W-1:0] sf_shadow = chse_pkg::SF_W'(chse_pkg::SF_RESET);
    int                        mismatches = 0;
    int                        symbols_checked = 0;
    int                        requests_sent = 0;
    int                        flagged_sent = 0;
    int                        sf_writes = 0;
    int                        cycles = 0;
    bit                        calm = 1'b0;
    bit                        hold_request = 1'b0;
    bit                        hold_active = 1'b0;

    // flagged rows carry their single beat typed in, the rest go through encode_header
    header_case_t directed_cases [0:N_DIRECTED-1] = '{
        '{4'd7,  8'h00, 1'b0, 3'd1, 1'b0, '0},
        '{4'd7,  8'hFF, 1'b1, 3'd4, 1'b0, '0},
        '{4'd7,  8'hA5, 1'b0, 3'd2, 1'b0, '0},
        '{4'd7,  8'h5A, 1'b1, 3'd3, 1'b0, '0},
        '{4'd7,  8'h00, 1'b0, 3'd0, 1'b1, '{12'd0, 3'd0, 1'b1, 1'b1}},
        '{4'd7,  8'hFF, 1'b1, 3'd5, 1'b1, '{12'd0, 3'd0, 1'b1, 1'b1}},
        '{4'd7,  8'h33, 1'b0, 3'd6, 1'b1, '{12'd0, 3'd0, 1'b1, 1'b1}},
        '{4'd7,  8'hFF, 1'b1, 3'd7, 1'b1, '{12'd0, 3'd0, 1'b1, 1'b1}},
        '{4'd5,  8'h00, 1'b0, 3'd1, 1'b0, '0},
        '{4'd5,  8'hFF, 1'b1, 3'd4, 1'b0, '0},
        '{4'd5,  8'h3C, 1'b0, 3'd2, 1'b0, '0},
        '{4'd6,  8'h81, 1'b1, 3'd3, 1'b0, '0},
        '{4'd6,  8'h7E, 1'b0, 3'd4, 1'b0, '0},
        '{4'd12, 8'hFF, 1'b1, 3'd4, 1'b0, '0},
        '{4'd12, 8'h01, 1'b0, 3'd1, 1'b0, '0},
        '{4'd12, 8'hC3, 1'b1, 3'd0, 1'b1, '{12'd0, 3'd0, 1'b1, 1'b1}},
        '{4'd0,  8'h12, 1'b0, 3'd2, 1'b0, '0},
        '{4'd15, 8'hED, 1'b1, 3'd3, 1'b0, '0},
        '{4'd4,  8'hC8, 1'b0, 3'd1, 1'b0, '0},
        '{4'd13, 8'h11, 1'b1, 3'd4, 1'b0, '0},
        '{4'd8,  8'h64, 1'b0, 3'd2, 1'b0, '0},
        '{4'd9,  8'h0F, 1'b1, 3'd3, 1'b0, '0},
        '{4'd10, 8'hF0, 1'b0, 3'd4, 1'b0, '0},
        '{4'd11, 8'h55, 1'b1, 3'd1, 1'b0, '0}
    };

    logic [chse_pkg::SF_W-1:0] phase_sf [0:N_PHASES-1] = '{
        4'd5, 4'd12, 4'd6, 4'd0, 4'd15, 4'd8, 4'd9, 4'd10, 4'd11, 4'd3, 4'd14, 4'd7
    };

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // append one expected beat at the tail of the pending list
    function automatic void queue_beat(input sym_beat_t b);
        symbols_due = {symbols_due, b};
    endfunction

    // expected symbol beats of one header request at the current spreading factor
    function automatic void encode_header(input logic [chse_pkg::LEN_W-1:0] len,
                                          input logic crc,
                                          input logic [chse_pkg::CR_W-1:0] cr);
        logic [11:0]                  hdr;
        logic [chse_pkg::CHK_W-1:0]   chk;
        logic [chse_pkg::NIB_W-1:0]   nib [0:SF_CEIL-1];
        logic [chse_pkg::CW_BITS-1:0] cw [0:SF_CEIL-1];
        logic [chse_pkg::NIB_W-1:0]   d;
        int unsigned                  sf;
        int unsigned                  rows;
        int unsigned                  mask;
        int unsigned                  word;
        int unsigned                  bin;
        int unsigned                  s;
        int unsigned                  rw;
        sym_beat_t                    beat;
        if (cr < chse_pkg::CR_MIN || cr > chse_pkg::CR_MAX)
        begin
            beat = '{symbol: '0, idx: '0, last: 1'b1, bad: 1'b1};
            queue_beat(beat);
            return;
        end
        sf = sf_shadow;
        if (sf < chse_pkg::MIN_SF)
            sf = chse_pkg::MIN_SF;
        if (sf > SF_CEIL)
            sf = SF_CEIL;
        rows = sf - 2;
        mask = (1 << sf) - 1;
        hdr = {len, crc, cr};
        chk = {^(hdr & 12'hF00), ^(hdr & 12'h8E8), ^(hdr & 12'h495),
               ^(hdr & 12'h25B), ^(hdr & 12'h12F)};
        for (int i = 0; i < SF_CEIL; i++)
            nib[i] = '0;
        nib[0] = len[7:4];
        nib[1] = len[3:0];
        nib[2] = {cr, crc};
        nib[3] = {3'b000, chk[4]};
        nib[4] = chk[3:0];
        // hamming(8,4): data reversed into the top nibble, parity below
        for (int r = 0; r < rows; r++)
        begin
            d = nib[r];
            cw[r][7] = d[0];
            cw[r][6] = d[1];
            cw[r][5] = d[2];
            cw[r][4] = d[3];
            cw[r][3] = d[0] ^ d[1] ^ d[2];
            cw[r][2] = d[1] ^ d[2] ^ d[3];
            cw[r][1] = d[0] ^ d[1] ^ d[3];
            cw[r][0] = ^cw[r][7:1];
        end
        for (int col = 0; col < chse_pkg::HDR_SYMBOLS; col++)
        begin
            word = 0;
            // diagonal walk: the k-th bit shifted in for column c comes from row (c - k - 1) mod rows
            for (int k = 0; k < rows; k++)
            begin
                rw = (col + 2 * rows - k - 1) % rows;
                word = (word << 1) | cw[rw][chse_pkg::CW_BITS-1-col];
            end
            bin = word;
            s = word >> 1;
            while (s != 0)
            begin
                bin = bin ^ s;
                s = s >> 1;
            end
            beat.symbol = chse_pkg::SYM_W'(((bin << 2) + 1) & mask);
            beat.idx    = chse_pkg::IDX_W'(col);
            beat.last   = (col == chse_pkg::HDR_SYMBOLS - 1);
            beat.bad    = 1'b0;
            queue_beat(beat);
        end
    endfunction

    task automatic note_mismatch(input string what, input sym_beat_t want,
                                 input sym_beat_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected sym=%0d idx=%0d last=%0b bad=%0b,",
                     $time, what, want.symbol, want.idx, want.last, want.bad);
            $display("    got sym=%0d idx=%0d last=%0b bad=%0b",
                     got.symbol, got.idx, got.last, got.bad);
        end
    endtask

    // offer one request, hold it until taken, then maybe idle
    task automatic offer_header(input logic [chse_pkg::LEN_W-1:0] len, input logic crc,
                                input logic [chse_pkg::CR_W-1:0] cr, input bit typed,
                                input sym_beat_t want);
        req_ch.valid          <= 1'b1;
        req_ch.payload_length <= len;
        req_ch.crc_present    <= crc;
        req_ch.coding_rate    <= cr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent++;
        if (cr < chse_pkg::CR_MIN || cr > chse_pkg::CR_MAX)
            flagged_sent++;
        if (typed)
            queue_beat(want);
        else
            encode_header(len, crc, cr);
        if (!calm && !hold_active && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (symbols_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sf(input logic [chse_pkg::SF_W-1:0] value);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sf_shadow = value;
        sf_writes++;
    endtask

    initial
    begin : stimulus
        header_case_t              hc;
        logic [chse_pkg::CR_W-1:0] cr;
        int                        pick;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_data              <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.payload_length <= '0;
        req_ch.crc_present    <= 1'b0;
        req_ch.coding_rate    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            hc = directed_cases[i];
            if (hc.sf != sf_shadow)
            begin
                drain();
                write_sf(hc.sf);
            end
            offer_header(hc.len, hc.crc, hc.cr, hc.typed, hc.want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            write_sf(phase_sf[p]);
            if (p == N_PHASES - 1)
                calm = 1'b1;
            // hold the symbol side off while requests keep coming
            if (p == 1)
                hold_request = 1'b1;
            for (int i = 0; i < PHASE_REQS; i++)
            begin
                if (p == 5 && i == PHASE_REQS / 2)
                    drain();
                if ($urandom_range(0, 7) == 0)
                begin
                    pick = $urandom_range(0, 3);
                    cr = (pick == 0) ? chse_pkg::CR_W'(0) : chse_pkg::CR_W'(4 + pick);
                end
                else
                    cr = chse_pkg::CR_W'($urandom_range(chse_pkg::CR_MIN, chse_pkg::CR_MAX));
                offer_header(chse_pkg::LEN_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), cr, 1'b0, '0);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (symbols_due.size() != 0)
            mismatches++;
        $display("covered %0d header requests (%0d with a bad coding rate), %0d beats checked",
                 requests_sent, flagged_sent, symbols_checked);
        $display("spreading factor written %0d times, out-of-range values included",
                 sf_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : symbol_sink
        int n;
        sym_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                sym_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_active  = 1'b0;
                sym_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 15);
                sym_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                sym_ch.ready <= 1'b1;
            end
            else
                sym_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : symbol_check
        sym_beat_t got;
        sym_beat_t want;
        if (rst_n && sym_ch.valid && sym_ch.ready)
        begin
            got = '{symbol: sym_ch.symbol, idx: sym_ch.symbol_index,
                    last: sym_ch.last, bad: sym_ch.bad_params};
            if (symbols_due.size() == 0)
                note_mismatch("beat with nothing pending", '0, got);
            else
            begin
                want = symbols_due.pop_front();
                symbols_checked++;
                if (got.symbol != want.symbol || got.idx != want.idx ||
                    got.last != want.last || got.bad != want.bad)
                    note_mismatch("symbol beat differs", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still pending", cycles,
                     symbols_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
